/* rtl/bfnb_pkg.sv */
// Shared types, constants and helpers for the bitmap find-next-bit block.
// Used by bfnb_store and bitmap_find_next_bit; depends on nothing else.
package bfnb_pkg;

   localparam int WORD_BITS = 64;
   localparam int NUM_WORDS = 64;
   localparam int IDX_W     = $clog2(NUM_WORDS);
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int POS_W     = 13;
   localparam int START_W   = 12;
   localparam int ACT_W     = 2;

   localparam logic [POS_W-1:0] BIT_CAP     = POS_W'(NUM_WORDS * WORD_BITS);
   localparam logic [POS_W-1:0] COUNT_RESET = POS_W'(4096);

   typedef enum logic [ACT_W-1:0] {
      ACT_WRITE      = 2'd0,
      ACT_FIND_SET   = 2'd1,
      ACT_FIND_CLEAR = 2'd2,
      ACT_NONE       = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK
   } state_type;

   typedef struct packed {
      logic                 en;
      logic [IDX_W-1:0]     idx;
      logic [WORD_BITS-1:0] data;
   } wr_req_type;

   function automatic logic [BIT_W-1:0] first_set(input logic [WORD_BITS-1:0] v);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = BIT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

/* rtl/bfnb_store.sv */
// Bitmap word store: one write port, one registered read port, per-word valid bits.
// A word never written since reset reads as zero. Depends on bfnb_pkg.
module bfnb_store
   import bfnb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  wr_req_type           wr,
   input  logic                 rd_en,
   input  logic [IDX_W-1:0]     rd_addr,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] mem_array [NUM_WORDS];
   logic [NUM_WORDS-1:0] vld_ff;
   logic [WORD_BITS-1:0] rd_word_ff;
   logic                 rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_array[wr.idx] <= wr.data;
      end
      if (rd_en) begin
         rd_word_ff <= mem_array[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            vld_ff[wr.idx] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_word_ff : '0;

endmodule

/* rtl/bitmap_find_next_bit.sv */
// Bitmap find-next-bit block: a write item stores one 64-bit bitmap word.
// A query item walks the words from the one holding start_offset upward, for each word doing
// one registered read of the word store and one masked compare and priority encode in the shared
// search unit. It stops at the first word with a match, at the last word below min(bit_count,
// 4096), or at the start word if start_offset is not below that bound; the block then returns to
// idle for the next item. The block takes no item while a query runs, and a result that finds the
// output register still full waits in the search unit until that register is taken.
module bitmap_find_next_bit
   import bfnb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [87:0]       req_tdata,   // word_index[5:0], word_data[69:6], start_offset[81:70]
   input  logic [ACT_W-1:0]  req_tuser,   // action[1:0]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata,   // position[12:0]
   output logic              rsp_tuser,   // found[0]
   input  logic              csr_wr_en,
   input  logic [POS_W-1:0]  csr_wr_data
);

   state_type            state_ff, state_in;
   logic [POS_W-1:0]     count_ff;
   logic [POS_W-1:0]     limit_ff, limit_in;
   logic [START_W-1:0]   start_ff, start_in;
   logic                 want_set_ff, want_set_in;
   logic [IDX_W-1:0]     cur_ff, cur_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]     rsp_pos_ff, rsp_pos_in;
   logic                 rsp_found_ff, rsp_found_in;

   action_type           act;
   logic [IDX_W-1:0]     req_idx;
   logic [WORD_BITS-1:0] req_data;
   logic [START_W-1:0]   req_start;
   logic                 accept;
   wr_req_type           wr;
   logic                 rd_en;
   logic [WORD_BITS-1:0] rd_data;

   logic [IDX_W-1:0]     start_word;
   logic [IDX_W:0]       limit_word;
   logic [IDX_W:0]       next_word;
   logic [POS_W-1:0]     next_base;
   logic [WORD_BITS-1:0] lo_mask, hi_mask, cand;
   logic                 hit, early, more, out_free, load;

   assign act       = action_type'(req_tuser);
   assign req_idx   = req_tdata[IDX_W-1:0];
   assign req_data  = req_tdata[6 +: WORD_BITS];
   assign req_start = req_tdata[70 +: START_W];
   assign accept    = req_tvalid && req_tready;

   assign wr.en   = accept && (act == ACT_WRITE);
   assign wr.idx  = req_idx;
   assign wr.data = req_data;

   bfnb_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (cur_ff),
      .rd_data (rd_data)
   );

   assign start_word = start_ff[BIT_W +: IDX_W];
   assign limit_word = limit_ff[POS_W-1:BIT_W];
   assign next_word  = (IDX_W+1)'(cur_ff) + (IDX_W+1)'(1);
   assign next_base  = POS_W'({next_word, BIT_W'(0)});

   assign lo_mask = (cur_ff == start_word) ? ({WORD_BITS{1'b1}} << start_ff[BIT_W-1:0])
                                           : {WORD_BITS{1'b1}};
   assign hi_mask = ({1'b0, cur_ff} == limit_word) ?
                    ~({WORD_BITS{1'b1}} << limit_ff[BIT_W-1:0]) : {WORD_BITS{1'b1}};
   assign cand    = (want_set_ff ? rd_data : ~rd_data) & lo_mask & hi_mask;
   assign hit     = |cand;
   assign early   = POS_W'(start_ff) >= limit_ff;
   assign more    = next_base < limit_ff;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      limit_in     = limit_ff;
      start_in     = start_ff;
      want_set_in  = want_set_ff;
      cur_in       = cur_ff;
      rd_en        = 1'b0;
      load         = 1'b0;
      rsp_pos_in   = rsp_pos_ff;
      rsp_found_in = rsp_found_ff;
      req_tready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept && (act == ACT_FIND_SET || act == ACT_FIND_CLEAR)) begin
               limit_in    = (count_ff < BIT_CAP) ? count_ff : BIT_CAP;
               start_in    = req_start;
               want_set_in = (act == ACT_FIND_SET);
               cur_in      = req_start[BIT_W +: IDX_W];
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (early || hit || !more) begin
               if (out_free) begin
                  load         = 1'b1;
                  rsp_found_in = !early && hit;
                  rsp_pos_in   = (!early && hit) ? POS_W'({cur_ff, first_set(cand)}) : count_ff;
                  state_in     = ST_IDLE;
               end
            end else begin
               cur_in   = next_word[IDX_W-1:0];
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      limit_ff     <= limit_in;
      start_ff     <= start_in;
      want_set_ff  <= want_set_in;
      cur_ff       <= cur_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 16'(rsp_pos_ff);
   assign rsp_tuser  = rsp_found_ff;

   a_found_below_count: assert property (@(posedge clock) disable iff (reset)
      load && rsp_found_in |-> rsp_pos_in < count_ff)
      else $error("found position not below bit count");

   a_miss_gives_count: assert property (@(posedge clock) disable iff (reset)
      load && !rsp_found_in |-> rsp_pos_in == count_ff)
      else $error("miss does not report bit count");

   a_found_not_before_start: assert property (@(posedge clock) disable iff (reset)
      load && rsp_found_in |-> rsp_pos_in >= POS_W'(start_ff))
      else $error("found position before start offset");

   a_check_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> state_ff == ST_CHECK)
      else $error("read not followed by check");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=>
         rsp_valid_ff && $stable(rsp_pos_ff) && $stable(rsp_found_ff))
      else $error("pending result overwritten");

endmodule
